@@ design/bpm_pkg.sv @@
package bpm_pkg;

	localparam int FIELD_W = 16;

	localparam logic [7:0] CHAR_OPEN    = 8'h5B;
	localparam logic [7:0] CHAR_CLOSE   = 8'h5D;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	typedef enum logic [2:0] {
		ST_PAIR      = 3'd0,
		ST_UNMATCHED = 3'd1,
		ST_OPEN_LEFT = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_DONE      = 3'd4
	} status_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] symbol;
	} item_t;

	typedef struct packed {
		status_t             status;
		logic [FIELD_W-1:0]  open_index;
		logic [FIELD_W-1:0]  open_line;
		logic [FIELD_W-1:0]  open_column;
		logic [FIELD_W-1:0]  close_index;
		logic [FIELD_W-1:0]  close_line;
		logic [FIELD_W-1:0]  close_column;
		logic [FIELD_W-1:0]  pair_count;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stk_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_status_t;

endpackage

@@ design/bpm_cell.sv @@
module bpm_cell #(
	parameter int ENTRY_W = 48
) (
	input  logic               clk,
	input  logic               push,
	input  logic               pop,
	input  logic [ENTRY_W-1:0] from_above,
	input  logic [ENTRY_W-1:0] from_below,
	output logic [ENTRY_W-1:0] entry
);
	logic [ENTRY_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		priority if (push) begin
			entry_q <= from_above;
		end else if (pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;
endmodule

@@ design/bpm_stack.sv @@
module bpm_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int ENTRY_W     = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpm_pkg::stk_ctrl_t    ctrl,
	input  logic [ENTRY_W-1:0]    push_entry,
	output logic [ENTRY_W-1:0]    top_entry,
	output bpm_pkg::stk_status_t  status
);
	import bpm_pkg::*;

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

	logic [DEPTH_W-1:0] depth_q;
	logic [ENTRY_W-1:0] chain [STACK_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			priority if (ctrl.clear) begin
				depth_q <= '0;
			end else if (ctrl.push) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (ctrl.pop) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [ENTRY_W-1:0] above;
		logic [ENTRY_W-1:0] below;

		if (i == 0) begin : g_head
			assign above = push_entry;
		end else begin : g_body
			assign above = chain[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_tail
			assign below = '0;
		end else begin : g_link
			assign below = chain[i+1];
		end

		bpm_cell #(
			.ENTRY_W(ENTRY_W)
		) u_cell (
			.clk       (clk),
			.push      (ctrl.push),
			.pop       (ctrl.pop),
			.from_above(above),
			.from_below(below),
			.entry     (chain[i])
		);
	end

	assign top_entry    = chain[0];
	assign status.empty = (depth_q == '0);
	assign status.full  = (depth_q == DEPTH_W'(STACK_DEPTH));
endmodule

@@ design/bracket_pair_matcher_top.sv @@
// Channel | Direction | Handshake                   | Payload
// item    | in        | item_valid / item_ready     | item   (bpm_pkg::item_t)
// result  | out       | result_valid / result_ready | result (bpm_pkg::result_t)
//
// One item per cycle while item_ready is high; a result is registered the cycle after its item's transfer.
// The stack is a chain of STACK_DEPTH cells; a push or pop shifts every cell together.
// item_ready drops only while a result waits in the output register and result_ready is low.
// Reset sets line to one, clears other counters, depth and error flag; stack cells are not cleared.
module bracket_pair_matcher_top #(
	parameter int STACK_DEPTH   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  bpm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output bpm_pkg::result_t result
);
	import bpm_pkg::*;

	localparam int P       = POSITION_BITS;
	localparam int ENTRY_W = 3 * P;
	localparam logic [P-1:0] POS_MAX = {P{1'b1}};
	localparam logic [P-1:0] POS_ONE = P'(1);

	logic [P-1:0] pos_q, line_q, col_q, pairs_q;
	logic         err_q;
	logic         result_valid_q;
	result_t      result_q;

	logic [P-1:0] pos_inc, line_inc, col_inc, pairs_inc;
	logic         accept, is_end, live_char;
	logic         is_open, is_close, is_nl;
	logic         overflow, underflow, emit;
	logic [ENTRY_W-1:0] top_entry;
	stk_ctrl_t    stk_ctrl;
	stk_status_t  stk_status;
	result_t      result_d;

	assign pos_inc   = (pos_q   == POS_MAX) ? POS_MAX : pos_q   + POS_ONE;
	assign line_inc  = (line_q  == POS_MAX) ? POS_MAX : line_q  + POS_ONE;
	assign col_inc   = (col_q   == POS_MAX) ? POS_MAX : col_q   + POS_ONE;
	assign pairs_inc = (pairs_q == POS_MAX) ? POS_MAX : pairs_q + POS_ONE;

	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;
	assign is_end     = (item.operation == OP_END);
	assign live_char  = accept && !is_end && !err_q;
	assign is_open    = (item.symbol == CHAR_OPEN);
	assign is_close   = (item.symbol == CHAR_CLOSE);
	assign is_nl      = (item.symbol == CHAR_NEWLINE);
	assign overflow   = live_char && is_open && stk_status.full;
	assign underflow  = live_char && is_close && stk_status.empty;

	assign stk_ctrl.push  = live_char && is_open && !stk_status.full;
	assign stk_ctrl.pop   = live_char && is_close && !stk_status.empty;
	assign stk_ctrl.clear = accept && is_end;

	assign emit = (accept && is_end && !err_q) || overflow || underflow || stk_ctrl.pop;

	bpm_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.ENTRY_W    (ENTRY_W)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (stk_ctrl),
		.push_entry({pos_q, line_q, col_inc}),
		.top_entry (top_entry),
		.status    (stk_status)
	);

	always_comb begin
		result_d              = '0;
		result_d.close_index  = FIELD_W'(pos_q);
		result_d.close_line   = FIELD_W'(line_q);
		result_d.close_column = FIELD_W'(col_inc);
		result_d.pair_count   = FIELD_W'(pairs_q);
		priority if (is_end) begin
			result_d.close_column = FIELD_W'(col_q);
			if (stk_status.empty) begin
				result_d.status = ST_DONE;
			end else begin
				result_d.status      = ST_OPEN_LEFT;
				result_d.open_index  = FIELD_W'(top_entry[3*P-1:2*P]);
				result_d.open_line   = FIELD_W'(top_entry[2*P-1:P]);
				result_d.open_column = FIELD_W'(top_entry[P-1:0]);
			end
		end else if (overflow) begin
			result_d.status = ST_OVERFLOW;
		end else if (underflow) begin
			result_d.status = ST_UNMATCHED;
		end else begin
			result_d.status      = ST_PAIR;
			result_d.open_index  = FIELD_W'(top_entry[3*P-1:2*P]);
			result_d.open_line   = FIELD_W'(top_entry[2*P-1:P]);
			result_d.open_column = FIELD_W'(top_entry[P-1:0]);
			result_d.pair_count  = FIELD_W'(pairs_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			line_q  <= POS_ONE;
			col_q   <= '0;
			pairs_q <= '0;
			err_q   <= 1'b0;
		end else if (accept && is_end) begin
			pos_q   <= '0;
			line_q  <= POS_ONE;
			col_q   <= '0;
			pairs_q <= '0;
			err_q   <= 1'b0;
		end else if (live_char) begin
			col_q <= is_nl ? '0 : col_inc;
			if (is_nl) begin
				line_q <= line_inc;
			end
			if (overflow || underflow) begin
				err_q <= 1'b1;
			end else begin
				pos_q <= pos_inc;
			end
			if (stk_ctrl.pop) begin
				pairs_q <= pairs_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_ready) begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule

@@ design/bpm_checker.sv @@
module bpm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input bpm_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input bpm_pkg::result_t result
);
	import bpm_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready))
		else $error("result without an item transfer");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output");

	a_open_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_UNMATCHED || result.status == ST_OVERFLOW
			|| result.status == ST_DONE)
		|-> result.open_index == '0 && result.open_line == '0 && result.open_column == '0)
		else $error("open fields set on a result without an open bracket");
endmodule

bind bracket_pair_matcher_top bpm_checker u_bpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.item        (item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import bpm_pkg::*;

	localparam int STACK_LIMIT = 64;
	localparam logic [FIELD_W-1:0] COUNT_TOP = '1;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	item_t   pending_items[$];
	result_t expected_results[$];
	int      queued_total = 0;
	int      taken_total = 0;
	int      errors = 0;
	int      send_gap = 0;
	int      ready_hold = 0;
	bit      steady = 1'b0;

	logic [FIELD_W-1:0] open_pos[STACK_LIMIT];
	logic [FIELD_W-1:0] open_ln[STACK_LIMIT];
	logic [FIELD_W-1:0] open_col[STACK_LIMIT];
	int                 open_depth = 0;
	logic [FIELD_W-1:0] char_pos = '0;
	logic [FIELD_W-1:0] line_no = FIELD_W'(1);
	logic [FIELD_W-1:0] col_no = '0;
	logic [FIELD_W-1:0] pairs = '0;
	bit                 err_seen = 1'b0;

	bracket_pair_matcher_top #(
		.STACK_DEPTH  (STACK_LIMIT),
		.POSITION_BITS(FIELD_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #5 clk = ~clk;

	function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
		return (v == COUNT_TOP) ? v : v + 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_char(logic [7:0] s);
		item_t it;
		it.operation = OP_CHAR;
		it.symbol = s;
		pending_items.push_back(it);
		queued_total++;
	endtask

	task automatic push_end();
		item_t it;
		it.operation = OP_END;
		it.symbol = 8'($urandom_range(0, 255));
		pending_items.push_back(it);
		queued_total++;
	endtask

	function automatic logic [7:0] pick_filler();
		logic [7:0] s;
		if ($urandom_range(0, 3) == 0)
			return CHAR_NEWLINE;
		do
			s = 8'($urandom_range(0, 255));
		while (s == CHAR_OPEN || s == CHAR_CLOSE);
		return s;
	endfunction

	task automatic predict_item(item_t it);
		result_t r;
		logic [FIELD_W-1:0] col;
		r = '0;
		if (it.operation == OP_END) begin
			if (!err_seen) begin
				r.close_index = char_pos;
				r.close_line = line_no;
				r.close_column = col_no;
				r.pair_count = pairs;
				if (open_depth > 0) begin
					r.status = ST_OPEN_LEFT;
					r.open_index = open_pos[open_depth-1];
					r.open_line = open_ln[open_depth-1];
					r.open_column = open_col[open_depth-1];
				end else begin
					r.status = ST_DONE;
				end
				expected_results.push_back(r);
			end
			open_depth = 0;
			char_pos = '0;
			line_no = FIELD_W'(1);
			col_no = '0;
			pairs = '0;
			err_seen = 1'b0;
			return;
		end
		if (err_seen)
			return;
		col = bump(col_no);
		col_no = col;
		r.close_index = char_pos;
		r.close_line = line_no;
		r.close_column = col;
		r.pair_count = pairs;
		if (it.symbol == CHAR_OPEN) begin
			if (open_depth >= STACK_LIMIT) begin
				r.status = ST_OVERFLOW;
				expected_results.push_back(r);
				err_seen = 1'b1;
				return;
			end
			open_pos[open_depth] = char_pos;
			open_ln[open_depth] = line_no;
			open_col[open_depth] = col;
			open_depth++;
		end else if (it.symbol == CHAR_CLOSE) begin
			if (open_depth == 0) begin
				r.status = ST_UNMATCHED;
				expected_results.push_back(r);
				err_seen = 1'b1;
				return;
			end
			open_depth--;
			pairs = bump(pairs);
			r.status = ST_PAIR;
			r.open_index = open_pos[open_depth];
			r.open_line = open_ln[open_depth];
			r.open_column = open_col[open_depth];
			r.pair_count = pairs;
			expected_results.push_back(r);
		end else if (it.symbol == CHAR_NEWLINE) begin
			line_no = bump(line_no);
			col_no = '0;
		end
		char_pos = bump(char_pos);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			if (errors <= 50)
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic wait_drained();
		while (taken_total != queued_total || expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (item_valid) begin
				if ($urandom_range(0, 99) == 0)
					steady = !steady;
				send_gap = pick_gap();
			end
			if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item_valid <= 1'b1;
				item <= pending_items.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				predict_item(item);
				taken_total++;
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 50)
						$display("%0t: unexpected transfer, status %0d close_index %0d",
							$time, result.status, result.close_index);
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, result.status);
					check_field("open_index", want.open_index, result.open_index);
					check_field("open_line", want.open_line, result.open_line);
					check_field("open_column", want.open_column, result.open_column);
					check_field("close_index", want.close_index, result.close_index);
					check_field("close_line", want.close_line, result.close_line);
					check_field("close_column", want.close_column, result.close_column);
					check_field("pair_count", want.pair_count, result.pair_count);
				end
			end
		end
		if (ready_hold > 0) begin
			ready_hold--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			if ($urandom_range(0, 4) == 0)
				ready_hold = pick_gap();
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int r;
		int cap;
		int len;
		int depth;
		int start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		push_end();
		push_char(8'h41);
		push_char(8'hFF);
		push_char(8'h00);
		push_char(CHAR_OPEN);
		push_char(CHAR_NEWLINE);
		push_char(CHAR_CLOSE);
		push_char(CHAR_CLOSE);
		push_char(CHAR_OPEN);
		push_char(CHAR_CLOSE);
		push_char(8'hFF);
		push_end();
		push_char(CHAR_OPEN);
		push_char(CHAR_OPEN);
		push_char(CHAR_CLOSE);
		push_end();
		repeat (STACK_LIMIT + 1) push_char(CHAR_OPEN);
		push_char(CHAR_CLOSE);
		push_end();

		start = queued_total;
		while (queued_total - start < 1250) begin
			r = $urandom_range(0, 99);
			depth = 0;
			if (r < 70) begin
				if ($urandom_range(0, 9) == 0) begin
					cap = $urandom_range(STACK_LIMIT - 4, STACK_LIMIT + 2);
					repeat (cap) begin
						push_char(CHAR_OPEN);
						depth++;
						if ($urandom_range(0, 7) == 0)
							push_char(pick_filler());
					end
				end else begin
					cap = $urandom_range(1, 8);
				end
				len = $urandom_range(1, 30);
				repeat (len) begin
					r = $urandom_range(0, 9);
					if (r < 4 && depth < cap) begin
						push_char(CHAR_OPEN);
						depth++;
					end else if (r < 7 && depth > 0) begin
						push_char(CHAR_CLOSE);
						depth--;
					end else begin
						push_char(pick_filler());
					end
				end
				if ($urandom_range(0, 2) != 0)
					repeat (depth) push_char(CHAR_CLOSE);
			end else if (r < 85) begin
				len = $urandom_range(1, 20);
				repeat (len) begin
					r = $urandom_range(0, 9);
					if (r < 3)
						push_char(CHAR_OPEN);
					else if (r < 6)
						push_char(CHAR_CLOSE);
					else
						push_char(pick_filler());
				end
			end else begin
				len = $urandom_range(1, 20);
				repeat (len) push_char(8'($urandom_range(0, 255)));
			end
			push_end();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
